FILE: hw/rtl/mrd_pkg.sv
// shared types and codes for the mqtt receive deframer
package mrd_pkg;

  localparam logic [2:0] ROLE_HEADER  = 3'd0;
  localparam logic [2:0] ROLE_LENGTH  = 3'd1;
  localparam logic [2:0] ROLE_TLEN    = 3'd2;
  localparam logic [2:0] ROLE_TOPIC   = 3'd3;
  localparam logic [2:0] ROLE_PID     = 3'd4;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd5;
  localparam logic [2:0] ROLE_IGNORED = 3'd6;

  localparam logic [3:0] KIND_PUBLISH = 4'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [2:0] byte_role;
    logic [7:0] data_out;
    logic [3:0] packet_kind;
    logic [1:0] qos_level;
    logic       packet_end;
    logic       publish_malformed;
    logic       length_error;
  } mrd_result_t;

endpackage

FILE: hw/rtl/mrd_parse.sv
// front end: per-byte packet parser that tags each byte with its role
module mrd_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  output mrd_pkg::mrd_result_t result
);
  import mrd_pkg::*;

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_LENGTH  = 3'd1;
  localparam logic [2:0] PH_TLEN    = 3'd2;
  localparam logic [2:0] PH_TOPIC   = 3'd3;
  localparam logic [2:0] PH_PID     = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_IGNORE  = 3'd6;

  logic [2:0]  phase, phase_next;
  logic [7:0]  hdr, hdr_next;
  logic [27:0] rem, rem_next;
  logic [1:0]  vidx, vidx_next;
  logic [15:0] tlen, tlen_next;
  logic [15:0] fcnt, fcnt_next;
  logic        malf, malf_next;

  logic [27:0] len_part;
  logic [27:0] rem_dec;
  logic [16:0] need;
  logic [15:0] fcnt_dec;
  logic        qos_nz;
  logic [2:0]  role;
  logic        pkt_end;
  logic        lerr;

  assign qos_nz   = (hdr[2:1] != 2'd0);
  assign rem_dec  = rem - 28'd1;
  assign fcnt_dec = fcnt - 16'd1;

  // 7-bit varint group placed at its weight
  always_comb begin
    unique case (vidx)
      2'd0: len_part = {21'd0, rx_byte[6:0]};
      2'd1: len_part = {14'd0, rx_byte[6:0], 7'd0};
      2'd2: len_part = {7'd0, rx_byte[6:0], 14'd0};
      default: len_part = {rx_byte[6:0], 21'd0};
    endcase
  end

  always_comb begin
    phase_next = phase;
    hdr_next   = hdr;
    rem_next   = rem;
    vidx_next  = vidx;
    tlen_next  = tlen;
    fcnt_next  = fcnt;
    malf_next  = malf;
    role       = ROLE_HEADER;
    pkt_end    = 1'b0;
    lerr       = 1'b0;
    need       = 17'd0;

    if (phase == PH_LENGTH) begin
      role     = ROLE_LENGTH;
      rem_next = rem | len_part;
      if (rx_byte[7]) begin
        if (vidx == 2'd3) begin
          lerr       = 1'b1;
          phase_next = PH_HEADER;
        end else begin
          vidx_next = vidx + 2'd1;
        end
      end else begin
        vidx_next = 2'd0;
        if (hdr[7:4] == KIND_PUBLISH) begin
          malf_next  = malf | (rem_next < 28'd2);
          phase_next = malf_next ? PH_IGNORE : PH_TLEN;
        end else begin
          phase_next = PH_IGNORE;
        end
        if (rem_next == 28'd0) begin
          pkt_end    = 1'b1;
          phase_next = PH_HEADER;
        end
      end
    end else if (phase >= PH_TLEN && phase <= PH_IGNORE) begin
      rem_next = rem_dec;
      unique case (phase)
        PH_TLEN: begin
          role = ROLE_TLEN;
          if (vidx == 2'd0) begin
            tlen_next = {rx_byte, 8'd0};
            vidx_next = 2'd1;
          end else begin
            tlen_next = tlen | {8'd0, rx_byte};
            vidx_next = 2'd0;
            need      = {1'b0, tlen_next} + (qos_nz ? 17'd2 : 17'd0);
            if ({11'd0, need} > rem_dec) begin
              malf_next  = 1'b1;
              phase_next = PH_IGNORE;
            end else if (tlen_next != 16'd0) begin
              phase_next = PH_TOPIC;
              fcnt_next  = tlen_next;
            end else if (qos_nz) begin
              phase_next = PH_PID;
              fcnt_next  = 16'd2;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
        PH_TOPIC: begin
          role      = ROLE_TOPIC;
          fcnt_next = fcnt_dec;
          if (fcnt_dec == 16'd0) begin
            if (qos_nz) begin
              phase_next = PH_PID;
              fcnt_next  = 16'd2;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
        PH_PID: begin
          role      = ROLE_PID;
          fcnt_next = fcnt_dec;
          if (fcnt_dec == 16'd0) phase_next = PH_PAYLOAD;
        end
        PH_PAYLOAD: role = ROLE_PAYLOAD;
        default:    role = ROLE_IGNORED;
      endcase
      if (rem_dec == 28'd0) begin
        pkt_end    = 1'b1;
        phase_next = PH_HEADER;
        vidx_next  = 2'd0;
      end
    end else begin
      // fixed header, also taken for the unused phase code
      hdr_next   = rx_byte;
      rem_next   = 28'd0;
      vidx_next  = 2'd0;
      tlen_next  = 16'd0;
      fcnt_next  = 16'd0;
      malf_next  = 1'b0;
      phase_next = PH_LENGTH;
    end
  end

  always_comb begin
    result.byte_role         = role;
    result.data_out          = rx_byte;
    result.packet_kind       = hdr_next[7:4];
    result.qos_level         = hdr_next[2:1];
    result.packet_end        = pkt_end;
    result.publish_malformed = malf_next;
    result.length_error      = lerr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      hdr   <= 8'd0;
      rem   <= 28'd0;
      vidx  <= 2'd0;
      tlen  <= 16'd0;
      fcnt  <= 16'd0;
      malf  <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      hdr   <= hdr_next;
      rem   <= rem_next;
      vidx  <= vidx_next;
      tlen  <= tlen_next;
      fcnt  <= fcnt_next;
      malf  <= malf_next;
    end
  end

endmodule

FILE: hw/rtl/mrd_fifo.sv
// back end: small result queue that holds tagged bytes until popped
module mrd_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  mrd_pkg::mrd_result_t wr_data,
  output logic                 full,
  input  logic                 rd_en,
  output mrd_pkg::mrd_result_t rd_data,
  output logic                 empty
);
  import mrd_pkg::*;

  mrd_result_t         slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_wr;
  logic                do_rd;

  assign full    = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + QUEUE_AW'(1);
      if (do_rd) rd_ptr <= rd_ptr + QUEUE_AW'(1);
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + (QUEUE_AW+1)'(1);
        2'b01:   count <= count - (QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/mqtt_receive_deframer.sv
// top level of the mqtt 3.1.1 receive deframer
//
// Takes received mqtt bytes one per transaction and returns one tagged result
// per byte, in order: its role (fixed header, remaining-length varint byte,
// topic length byte, topic byte, packet id byte, payload byte or ignored body
// byte), the byte itself, the packet type and qos of the current fixed header,
// an end-of-packet mark, a malformed-publish flag and a length error on an
// overlong varint. A byte is taken in a clock cycle when push is high and full is low; the
// parser updates its whole state in the cycle a byte is taken, so one byte per
// cycle is sustained while full is low. Its result is written into a
// four-entry queue and shows on the result ports once older results are popped.
// The queue lets the consumer stall without stopping the input until four results wait.
module mqtt_receive_deframer (
  input  logic       clk,
  input  logic       rst,
  // input side
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  // result side
  output logic       empty,
  input  logic       pop,
  output logic [2:0] byte_role,
  output logic [7:0] data_out,
  output logic [3:0] packet_kind,
  output logic [1:0] qos_level,
  output logic       packet_end,
  output logic       publish_malformed,
  output logic       length_error
);
  import mrd_pkg::*;

  mrd_result_t parsed;
  mrd_result_t head;
  logic        accept;

  // a byte is taken only when the queue has room for its result
  assign accept = push && !full;

  // front: parser state machine
  mrd_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .result  (parsed)
  );

  // back: result queue toward the consumer
  mrd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (parsed),
    .full    (full),
    .rd_en   (pop),
    .rd_data (head),
    .empty   (empty)
  );

  // oldest waiting result onto the ports
  assign byte_role         = head.byte_role;
  assign data_out          = head.data_out;
  assign packet_kind       = head.packet_kind;
  assign qos_level         = head.qos_level;
  assign packet_end        = head.packet_end;
  assign publish_malformed = head.publish_malformed;
  assign length_error      = head.length_error;

endmodule
